>>> hdl/fsmf_pkg.sv
package fsmf_pkg;

  // Depth of the byte window and the longest needle the block can match.
  localparam int MaxNeedle = 16;
  localparam int WinIdxW   = (MaxNeedle > 1) ? $clog2(MaxNeedle) : 1;

  // Needle bytes held by the two 64-bit configuration registers.
  localparam int CfgNeedleBytes = 16;
  localparam int NeedleLenW     = 5;
  localparam int CfgDataW       = 64;
  localparam int CfgIdxW        = 2;
  localparam int PosW           = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegNeedleLength = 2'd0,
    RegNeedleLow    = 2'd1,
    RegNeedleHigh   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] match_position;
  } out_t;

  typedef struct packed {
    logic [NeedleLenW-1:0]       needle_length;
    logic [8*CfgNeedleBytes-1:0] needle;
  } cfg_t;

  typedef struct packed {
    logic emit;
    out_t res;
  } core_res_t;

endpackage

>>> hdl/first_substring_match_finder.sv
// The accepted byte is held in the input register, and its result is loaded into
// the result register, where it waits until out_ready_i takes it.
// Throughput: one haystack byte per cycle; the window compare is combinational
// logic between the input register and the result register. The input stalls
// only while a waiting result is held by out_ready_i.
// Reset clears the needle registers to zero, the byte window, the position
// counter and the reported flag; out_valid_o goes low and in_ready_o is high.
module first_substring_match_finder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fsmf_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fsmf_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [fsmf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fsmf_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import fsmf_pkg::*;

  cfg_t      cfg;
  core_res_t core_res;
  logic      s1_valid_q;
  in_t       s1_data_q;
  logic      out_valid_q;
  out_t      out_data_q;
  logic      s1_advance;

  fsmf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fsmf_match_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_advance),
    .item_i (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (core_res)
  );

  // The registered byte moves on whenever the result register is free or
  // being emptied in the same cycle.
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance && core_res.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && core_res.emit) begin
      out_data_q <= core_res.res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> hdl/fsmf_cfg_regs.sv
module fsmf_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fsmf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fsmf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output fsmf_pkg::cfg_t                 cfg_o
);
  import fsmf_pkg::*;

  logic [NeedleLenW-1:0] len_q;
  logic [CfgDataW-1:0]   low_q;
  logic [CfgDataW-1:0]   high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      low_q  <= '0;
      high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegNeedleLength: len_q  <= cfg_wdata_i[NeedleLenW-1:0];
        RegNeedleLow:    low_q  <= cfg_wdata_i;
        RegNeedleHigh:   high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.needle_length = len_q;
  assign cfg_o.needle        = {high_q, low_q};

endmodule

>>> hdl/fsmf_match_core.sv
module fsmf_match_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  fsmf_pkg::in_t       item_i,
  input  fsmf_pkg::cfg_t      cfg_i,
  output fsmf_pkg::core_res_t res_o
);
  import fsmf_pkg::*;

  logic [7:0]            win_q [MaxNeedle];
  logic [7:0]            win_new [MaxNeedle];
  logic [PosW-1:0]       seen_q;
  logic                  reported_q;
  logic [NeedleLenW-1:0] len;
  logic                  mismatch;
  logic                  sat;
  logic                  hit;
  logic [7:0]            nb;

  always_comb begin
    int idx;
    idx = 0;
    if (int'(cfg_i.needle_length) > MaxNeedle) begin
      len = NeedleLenW'(MaxNeedle);
    end else begin
      len = cfg_i.needle_length;
    end

    // Index 0 holds the newest byte.
    win_new[0] = item_i.data_byte;
    for (int i = 1; i < MaxNeedle; i++) begin
      win_new[i] = win_q[i-1];
    end

    // Needle byte j must sit at window index len-1-j.
    mismatch = 1'b0;
    nb       = 8'd0;
    for (int j = 0; j < MaxNeedle; j++) begin
      nb = (j < CfgNeedleBytes) ? cfg_i.needle[8*(j % CfgNeedleBytes) +: 8] : 8'd0;
      if (j < int'(len)) begin
        idx = int'(len) - 1 - j;
        if (win_new[idx[WinIdxW-1:0]] != nb) begin
          mismatch = 1'b1;
        end
      end
    end

    sat = &seen_q;
    if (reported_q || sat) begin
      hit = 1'b0;
    end else if (len == '0) begin
      hit = (seen_q == '0);
    end else begin
      hit = (seen_q >= (PosW'(len) - PosW'(1))) && !mismatch;
    end

    res_o.emit               = !reported_q && (hit || item_i.last_byte);
    res_o.res.found          = hit;
    res_o.res.match_position = (hit && (len != '0)) ?
                               (seen_q + PosW'(1) - PosW'(len)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxNeedle; i++) begin
        win_q[i] <= 8'd0;
      end
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        // End of the haystack: start clean for the next string.
        for (int i = 0; i < MaxNeedle; i++) begin
          win_q[i] <= 8'd0;
        end
        seen_q     <= '0;
        reported_q <= 1'b0;
      end else if (!reported_q) begin
        for (int i = 0; i < MaxNeedle; i++) begin
          win_q[i] <= win_new[i];
        end
        if (!sat) begin
          seen_q <= seen_q + PosW'(1);
        end
        if (hit) begin
          reported_q <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/fsmf_checker.sv
module fsmf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input fsmf_pkg::out_t                out_data_o
);
  import fsmf_pkg::*;

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while stalled");

  // A not-found result always reports position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.match_position == '0))
    else $error("not-found result carries a nonzero position");

  // A fresh result must be preceded by an accepted input transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input transaction");

  // With the result register empty, the input side never stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while result register empty");

endmodule

bind first_substring_match_finder fsmf_checker u_fsmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> sim/first_substring_match_finder_tb.sv
`timescale 1ns / 100ps

module first_substring_match_finder_tb;
  import fsmf_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 1050;
  localparam int DrainCycles = 8;
  localparam int Haystacks   = 6;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  class substring_scoreboard;
    logic [NeedleLenW-1:0] len_reg;
    logic [CfgDataW-1:0]   low_reg;
    logic [CfgDataW-1:0]   high_reg;
    logic [7:0]            window [MaxNeedle];
    logic [PosW-1:0]       seen;
    bit                    reported;
    out_t                  expected_q [$];
    int                    errors;

    function new();
      len_reg  = '0;
      low_reg  = '0;
      high_reg = '0;
      errors   = 0;
      clear_haystack();
    endfunction

    function void clear_haystack();
      foreach (window[i]) window[i] = '0;
      seen     = '0;
      reported = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        RegNeedleLength: len_reg = value[NeedleLenW-1:0];
        RegNeedleLow:    low_reg = value;
        RegNeedleHigh:   high_reg = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] needle_byte(int j);
      if (j < 8) return low_reg[8*j +: 8];
      if (j < 16) return high_reg[8*(j-8) +: 8];
      return '0;
    endfunction

    // Window slot 0 holds the newest byte, so needle byte j sits at slot len-1-j.
    function void note_input(in_t item);
      int unsigned     eff_len;
      bit              hit;
      logic [PosW-1:0] pos;
      out_t            res;
      eff_len = (len_reg > MaxNeedle) ? MaxNeedle : len_reg;
      hit = 1'b0;
      res = '0;
      if (!reported) begin
        pos = seen;
        for (int i = MaxNeedle - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = item.data_byte;
        if (seen != '1) begin
          seen = pos + 1'b1;
          if (eff_len == 0) begin
            hit = (pos == '0);
          end else if (seen >= eff_len) begin
            hit = 1'b1;
            for (int j = 0; j < eff_len; j++) begin
              if (window[eff_len-1-j] != needle_byte(j)) hit = 1'b0;
            end
            res.match_position = seen - eff_len;
          end
        end
        if (hit) begin
          reported = 1'b1;
          res.found = 1'b1;
          expected_q.push_back(res);
        end else if (item.last_byte) begin
          expected_q.push_back(out_t'('0));
        end
      end
      if (item.last_byte) clear_haystack();
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result found=%0b match_position=%0d",
                 $time, got.found, got.match_position);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0b, actual %0b",
                 $time, want.found, got.found);
        errors++;
      end
      if (got.match_position !== want.match_position) begin
        $display("%0t: match_position mismatch, expected %0d, actual %0d",
                 $time, want.match_position, got.match_position);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  out_t                out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  substring_scoreboard sb;
  bit                  no_idle;
  int                  items_sent;
  int                  cycles;
  int unsigned         cur_len;
  logic [7:0]          needle_seq [$];
  logic [7:0]          hay_bytes [$];

  first_substring_match_finder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("first_substring_match_finder test failed");
      $finish;
    end
  end

  // Everything the block sees at an edge goes to the scoreboard at that edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && in_ready_o === 1'b1) sb.note_input(in_data_i);
      if (out_valid_o === 1'b1 && out_ready_i) sb.check_result(out_data_o);
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= 16);
  end

  task automatic drive_byte(logic [7:0] b, logic last);
    if (!no_idle && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= in_t'{data_byte: b, last_byte: last};
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_haystack();
    foreach (hay_bytes[i]) drive_byte(hay_bytes[i], i == hay_bytes.size() - 1);
  endtask

  // A byte after a match gives no result, so the block may still be busy
  // when the scoreboard runs dry; let the pipeline drain as well.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_needle(logic [NeedleLenW-1:0] len, logic [CfgDataW-1:0] low,
                              logic [CfgDataW-1:0] high);
    logic [CfgDataW-1:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[NeedleLenW-1:0] = len;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegUnused;
    cfg_wdata_i <= {$urandom, $urandom};
    @(negedge clk_i);
    cfg_idx_i   <= RegNeedleLength;
    cfg_wdata_i <= len_word;
    @(negedge clk_i);
    cfg_idx_i   <= RegNeedleLow;
    cfg_wdata_i <= low;
    @(negedge clk_i);
    cfg_idx_i   <= RegNeedleHigh;
    cfg_wdata_i <= high;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    cur_len = (len > MaxNeedle) ? MaxNeedle : len;
    needle_seq.delete();
    for (int j = 0; j < cur_len; j++) begin
      needle_seq.push_back((j < 8) ? low[8*j +: 8] : high[8*(j-8) +: 8]);
    end
  endtask

  initial begin
    int                    style;
    int                    n;
    int                    p;
    int                    keep;
    int                    sel;
    int                    phase;
    logic [NeedleLenW-1:0] len;
    logic [CfgDataW-1:0]   low;
    logic [CfgDataW-1:0]   high;

    sb          = new();
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    no_idle     = 1'b0;
    items_sent  = 0;
    cycles      = 0;
    cur_len     = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty needle straight out of reset matches on the first byte.
    hay_bytes = '{8'h00};
    send_haystack();

    // A zero needle against the zeroed window must not match a short haystack.
    wait_idle();
    write_needle(NeedleLenW'(4), '0, {$urandom, $urandom});
    hay_bytes = '{8'h00, 8'h00, 8'h00};
    send_haystack();

    // Single-byte needle that only appears on the final byte.
    wait_idle();
    low = {$urandom, $urandom};
    low[7:0] = 8'hFF;
    write_needle(NeedleLenW'(1), low, '0);
    hay_bytes = '{8'h00, 8'hFF};
    send_haystack();

    // Oversized length clamps to the full window; the trailing byte is ignored.
    wait_idle();
    write_needle(NeedleLenW'(31), '0, '1);
    hay_bytes.delete();
    repeat (8) hay_bytes.push_back(8'h00);
    repeat (8) hay_bytes.push_back(8'hFF);
    hay_bytes.push_back(8'h55);
    send_haystack();

    items_sent = 0;
    phase = 0;
    while (items_sent < RandomItems) begin
      wait_idle();
      no_idle = (phase >= 4 && phase < 8);
      sel = $urandom_range(0, 9);
      case (sel)
        0:       len = '0;
        1:       len = NeedleLenW'(MaxNeedle);
        2:       len = NeedleLenW'($urandom_range(MaxNeedle + 1, 31));
        default: len = NeedleLenW'($urandom_range(1, 8));
      endcase
      sel = $urandom_range(0, 5);
      if (sel == 0) begin
        low  = '0;
        high = '0;
      end else if (sel == 1) begin
        low  = '1;
        high = '1;
      end else if (sel < 4) begin
        // Two-letter needles overlap with themselves and stress the window.
        for (int k = 0; k < 8; k++) begin
          low[8*k +: 8]  = 8'h61 + 8'($urandom_range(0, 1));
          high[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 1));
        end
      end else begin
        low  = {$urandom, $urandom};
        high = {$urandom, $urandom};
      end
      write_needle(len, low, high);

      repeat (Haystacks) begin
        style = $urandom_range(0, 99);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 48) : $urandom_range(1, 20);
        if (style < 60) n = cur_len + $urandom_range(0, 12);
        if (n < 1) n = 1;
        hay_bytes.delete();
        for (int i = 0; i < n; i++) begin
          if (style < 85 && cur_len > 0 && $urandom_range(0, 1) == 1) begin
            hay_bytes.push_back(needle_seq[$urandom_range(0, cur_len - 1)]);
          end else begin
            hay_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end
        if (style < 60 && cur_len > 0) begin
          p = $urandom_range(0, n - cur_len);
          for (int j = 0; j < cur_len; j++) hay_bytes[p+j] = needle_seq[j];
          if ($urandom_range(0, 3) == 0) begin
            hay_bytes[p + $urandom_range(0, cur_len - 1)] ^= 8'($urandom_range(1, 255));
          end
        end else if (style < 85 && cur_len > 1) begin
          // Leave only a prefix of the needle hanging off the end.
          keep = $urandom_range(1, cur_len - 1);
          if (keep <= n) begin
            for (int j = 0; j < keep; j++) hay_bytes[n-keep+j] = needle_seq[j];
          end
        end
        send_haystack();
      end
      phase++;
    end

    no_idle = 1'b0;
    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("first_substring_match_finder test passed");
    end else begin
      $display("first_substring_match_finder test failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/fsmf_pkg.sv
hdl/fsmf_cfg_regs.sv
hdl/fsmf_match_core.sv
hdl/first_substring_match_finder.sv
hdl/fsmf_checker.sv
sim/first_substring_match_finder_tb.sv
